@@ design/epoch_seconds_datetime_converter_defines.svh @@
// Assertion macros for the epoch seconds / calendar converter.
// Used by the top level; SYNTH builds get empty bodies.
`ifndef EPOCH_SECONDS_DATETIME_CONVERTER_DEFINES_SVH
`define EPOCH_SECONDS_DATETIME_CONVERTER_DEFINES_SVH
`ifndef SYNTH
`define ESDC_ASSERT_SAME(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("esdc assertion failed");
`define ESDC_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("esdc assertion failed");
`else
`define ESDC_ASSERT_SAME(lbl, a, b)
`define ESDC_ASSERT_NEXT(lbl, a, b)
`endif
`endif

@@ design/esdc_pkg.sv @@
// Package for the epoch seconds / calendar converter: payload types,
// constants and calendar tables. No dependencies.
`timescale 1ns / 1ps
package esdc_pkg;

    localparam int STAGES = 7;

    localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [16:0] SECS_PER_MIN  = 17'd60;
    localparam logic [11:0] EPOCH_YEAR    = 12'd1900;

    // floor(2^41 / 675): seconds / 128 / 675 gives whole days
    localparam logic [31:0] RECIP_DAY  = 32'd3257812230;
    // floor(2^19 / 100)
    localparam logic [12:0] RECIP_100  = 13'd5242;
    // floor(2^28 / 1461)
    localparam logic [17:0] RECIP_1461 = 18'd183734;
    // floor(2^29 / 3600)
    localparam logic [17:0] RECIP_3600 = 18'd149130;
    // floor(2^16 / 60)
    localparam logic [10:0] RECIP_60   = 11'd1092;

    // leap days in years 1 .. 1899
    localparam logic [20:0] LEAPS_BEFORE_EPOCH = 21'd460;

    typedef struct packed {
        logic        func;
        logic [31:0] seconds_in;
        logic [11:0] year_in;
        logic [3:0]  month_in;
        logic [4:0]  day_in;
        logic [4:0]  hour_in;
        logic [5:0]  minute_in;
        logic [5:0]  second_in;
    } cmd_t;

    typedef struct packed {
        logic [31:0] seconds_out;
        logic [10:0] year_out;
        logic [3:0]  month_out;
        logic [4:0]  day_out;
        logic [4:0]  hour_out;
        logic [5:0]  minute_out;
        logic [5:0]  second_out;
        logic        error;
    } rsp_t;

    function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
        logic [8:0] base;
        case (m)
            4'd1:    base = 9'd0;
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            4'd12:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && (m >= 4'd3) && (m <= 4'd12))
            base = base + 9'd1;
        return base;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

@@ design/esdc_cmd_if.sv @@
// Input channel of the converter: valid, ready and one command.
// Depends on esdc_pkg.
`timescale 1ns / 1ps
interface esdc_cmd_if;
    logic            valid;
    logic            ready;
    esdc_pkg::cmd_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/esdc_rsp_if.sv @@
// Output channel of the converter: valid, ready and one result.
// Depends on esdc_pkg.
`timescale 1ns / 1ps
interface esdc_rsp_if;
    logic            valid;
    logic            ready;
    esdc_pkg::rsp_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/epoch_seconds_datetime_converter.sv @@
// Epoch seconds / calendar converter, seven-stage pipeline.
// Throughput: one transaction per cycle; a stalled output holds every stage.
// Reset: rst_n clears the stage valid bits only.
// Depends on esdc_pkg, esdc_cmd_if, esdc_rsp_if and the defines header.
`timescale 1ns / 1ps
`include "epoch_seconds_datetime_converter_defines.svh"
module epoch_seconds_datetime_converter (
    input  logic       clk,
    input  logic       rst_n,
    esdc_cmd_if.sink   cmd,
    esdc_rsp_if.source rsp
);

    logic                           adv;
    logic [esdc_pkg::STAGES-1:0]    valid_reg;
    logic [esdc_pkg::STAGES-1:0]    valid_next;

    // stage 1
    esdc_pkg::cmd_t s1_cmd_reg, s1_cmd_next;
    logic [15:0]    s1_dq_reg, s1_dq_next;
    logic [5:0]     s1_eq_reg, s1_eq_next;
    logic [56:0]    s1_dprod;
    logic [24:0]    s1_eprod;

    // stage 2
    esdc_pkg::cmd_t s2_cmd_reg, s2_cmd_next;
    logic [15:0]    s2_days_reg, s2_days_next;
    logic [16:0]    s2_rem_reg, s2_rem_next;
    logic [5:0]     s2_q100_reg, s2_q100_next;
    logic           s2_rz_reg, s2_rz_next;
    logic           s2_leap_reg, s2_leap_next;
    logic [16:0]    s2_tod_reg, s2_tod_next;
    logic           s2_fok_reg, s2_fok_next;
    logic [31:0]    s2_drem;
    logic [11:0]    s2_erem;
    logic [7:0]     s2_r8;

    // stage 3
    esdc_pkg::cmd_t s3_cmd_reg, s3_cmd_next;
    logic [15:0]    s3_dd_reg, s3_dd_next;
    logic [5:0]     s3_y4q_reg, s3_y4q_next;
    logic [16:0]    s3_rem_reg, s3_rem_next;
    logic [4:0]     s3_hq_reg, s3_hq_next;
    logic [20:0]    s3_dby_reg, s3_dby_next;
    logic [8:0]     s3_mdays_reg, s3_mdays_next;
    logic           s3_eok_reg, s3_eok_next;
    logic [16:0]    s3_tod_reg, s3_tod_next;
    logic [33:0]    s3_yprod;
    logic [34:0]    s3_hprod;
    logic [5:0]     s3_e1;
    logic [11:0]    s3_ym1;
    logic [11:0]    s3_n;
    logic [20:0]    s3_leaps;

    // stage 4
    logic           s4_func_reg, s4_func_next;
    logic [5:0]     s4_y4_reg, s4_y4_next;
    logic [11:0]    s4_r_reg, s4_r_next;
    logic [4:0]     s4_hour_reg, s4_hour_next;
    logic [11:0]    s4_rem_reg, s4_rem_next;
    logic [20:0]    s4_edays_reg, s4_edays_next;
    logic           s4_eok_reg, s4_eok_next;
    logic [16:0]    s4_tod_reg, s4_tod_next;
    logic [15:0]    s4_r0;
    logic [16:0]    s4_m0;

    // stage 5
    logic           s5_func_reg, s5_func_next;
    logic [10:0]    s5_year_reg, s5_year_next;
    logic [8:0]     s5_doy_reg, s5_doy_next;
    logic           s5_leap_reg, s5_leap_next;
    logic [4:0]     s5_hour_reg, s5_hour_next;
    logic [11:0]    s5_rem_reg, s5_rem_next;
    logic [5:0]     s5_mq_reg, s5_mq_next;
    logic [37:0]    s5_total_reg, s5_total_next;
    logic           s5_eok_reg, s5_eok_next;
    logic [1:0]     s5_yoff;
    logic [11:0]    s5_start;
    logic [11:0]    s5_doy12;
    logic [22:0]    s5_mprod;

    // stage 6
    logic           s6_func_reg, s6_func_next;
    logic [10:0]    s6_year_reg, s6_year_next;
    logic [8:0]     s6_doy_reg, s6_doy_next;
    logic           s6_leap_reg, s6_leap_next;
    logic [4:0]     s6_hour_reg, s6_hour_next;
    logic [5:0]     s6_minute_reg, s6_minute_next;
    logic [5:0]     s6_second_reg, s6_second_next;
    logic [3:0]     s6_month_reg, s6_month_next;
    logic [31:0]    s6_seconds_reg, s6_seconds_next;
    logic           s6_err_reg, s6_err_next;
    logic [11:0]    s6_sec0;

    // stage 7 (output)
    esdc_pkg::rsp_t s7_rsp_reg, s7_rsp_next;
    logic [8:0]     s7_day0;

    assign adv        = !valid_reg[esdc_pkg::STAGES-1] || rsp.ready;
    assign cmd.ready  = adv;
    assign rsp.valid  = valid_reg[esdc_pkg::STAGES-1];
    assign rsp.data   = s7_rsp_reg;
    assign valid_next = {valid_reg[esdc_pkg::STAGES-2:0], cmd.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= valid_next;
    end

    always_comb
    begin
        s1_cmd_next = cmd.data;
        s1_dprod    = 57'(cmd.data.seconds_in[31:7]) * 57'(esdc_pkg::RECIP_DAY);
        s1_dq_next  = s1_dprod[56:41];
        s1_eprod    = 25'(cmd.data.year_in) * 25'(esdc_pkg::RECIP_100);
        s1_eq_next  = s1_eprod[24:19];
    end

    always_comb
    begin
        s2_cmd_next = s1_cmd_reg;
        s2_drem = s1_cmd_reg.seconds_in - (32'(s1_dq_reg) * esdc_pkg::SECS_PER_DAY);
        if (s2_drem[17:0] >= esdc_pkg::SECS_PER_DAY[17:0])
        begin
            s2_days_next = s1_dq_reg + 16'd1;
            s2_rem_next  = 17'(s2_drem[17:0] - esdc_pkg::SECS_PER_DAY[17:0]);
        end
        else
        begin
            s2_days_next = s1_dq_reg;
            s2_rem_next  = s2_drem[16:0];
        end
        s2_erem = s1_cmd_reg.year_in - (12'(s1_eq_reg) * 12'd100);
        if (s2_erem[7:0] >= 8'd100)
        begin
            s2_q100_next = s1_eq_reg + 6'd1;
            s2_r8        = s2_erem[7:0] - 8'd100;
        end
        else
        begin
            s2_q100_next = s1_eq_reg;
            s2_r8        = s2_erem[7:0];
        end
        s2_rz_next   = (s2_r8 == 8'd0);
        s2_leap_next = (s1_cmd_reg.year_in[1:0] == 2'd0) &&
                       ((s2_r8 != 8'd0) || (s2_q100_next[1:0] == 2'd0));
        s2_tod_next  = 17'(s1_cmd_reg.hour_in) * esdc_pkg::SECS_PER_HOUR +
                       17'(s1_cmd_reg.minute_in) * esdc_pkg::SECS_PER_MIN +
                       17'(s1_cmd_reg.second_in);
        s2_fok_next  = (s1_cmd_reg.year_in >= esdc_pkg::EPOCH_YEAR) &&
                       (s1_cmd_reg.month_in >= 4'd1) && (s1_cmd_reg.month_in <= 4'd12) &&
                       (s1_cmd_reg.day_in >= 5'd1) && (s1_cmd_reg.hour_in <= 5'd23) &&
                       (s1_cmd_reg.minute_in <= 6'd59) && (s1_cmd_reg.second_in <= 6'd59);
    end

    always_comb
    begin
        s3_cmd_next = s2_cmd_reg;
        // fold in a virtual Feb 29 1900 so every 4-year block starts leap
        s3_dd_next  = s2_days_reg + 16'(s2_days_reg >= 16'd59);
        s3_yprod    = 34'(s3_dd_next) * 34'(esdc_pkg::RECIP_1461);
        s3_y4q_next = s3_yprod[33:28];
        s3_hprod    = 35'(s2_rem_reg) * 35'(esdc_pkg::RECIP_3600);
        s3_hq_next  = s3_hprod[33:29];
        s3_rem_next = s2_rem_reg;
        s3_e1       = s2_q100_reg - 6'(s2_rz_reg);
        s3_ym1      = s2_cmd_reg.year_in - 12'd1;
        s3_leaps    = 21'(s3_ym1[11:2]) - 21'(s3_e1) + 21'(s3_e1[5:2]) -
                      esdc_pkg::LEAPS_BEFORE_EPOCH;
        s3_n        = s2_cmd_reg.year_in - esdc_pkg::EPOCH_YEAR;
        s3_dby_next = 21'(s3_n) * 21'd365 + s3_leaps;
        s3_mdays_next = esdc_pkg::month_start(s2_cmd_reg.month_in, s2_leap_reg) +
                        9'(s2_cmd_reg.day_in) - 9'd1;
        s3_eok_next = s2_fok_reg &&
                      (s2_cmd_reg.day_in <= esdc_pkg::month_len(s2_cmd_reg.month_in,
                                                                s2_leap_reg));
        s3_tod_next = s2_tod_reg;
    end

    always_comb
    begin
        s4_func_next = s3_cmd_reg.func;
        s4_r0 = s3_dd_reg - (16'(s3_y4q_reg) * 16'd1461);
        if (s4_r0[11:0] >= 12'd1461)
        begin
            s4_y4_next = s3_y4q_reg + 6'd1;
            s4_r_next  = s4_r0[11:0] - 12'd1461;
        end
        else
        begin
            s4_y4_next = s3_y4q_reg;
            s4_r_next  = s4_r0[11:0];
        end
        s4_m0 = s3_rem_reg - (17'(s3_hq_reg) * esdc_pkg::SECS_PER_HOUR);
        if (s4_m0[12:0] >= esdc_pkg::SECS_PER_HOUR[12:0])
        begin
            s4_hour_next = s3_hq_reg + 5'd1;
            s4_rem_next  = 12'(s4_m0[12:0] - esdc_pkg::SECS_PER_HOUR[12:0]);
        end
        else
        begin
            s4_hour_next = s3_hq_reg;
            s4_rem_next  = s4_m0[11:0];
        end
        s4_edays_next = s3_dby_reg + 21'(s3_mdays_reg);
        s4_eok_next   = s3_eok_reg;
        s4_tod_next   = s3_tod_reg;
    end

    always_comb
    begin
        s5_func_next = s4_func_reg;
        if (s4_r_reg < 12'd366)
        begin
            s5_yoff  = 2'd0;
            s5_start = 12'd0;
        end
        else if (s4_r_reg < 12'd731)
        begin
            s5_yoff  = 2'd1;
            s5_start = 12'd366;
        end
        else if (s4_r_reg < 12'd1096)
        begin
            s5_yoff  = 2'd2;
            s5_start = 12'd731;
        end
        else
        begin
            s5_yoff  = 2'd3;
            s5_start = 12'd1096;
        end
        s5_doy12      = s4_r_reg - s5_start;
        s5_doy_next   = s5_doy12[8:0];
        s5_leap_next  = (s5_yoff == 2'd0);
        s5_year_next  = 11'(esdc_pkg::EPOCH_YEAR) + 11'({s4_y4_reg, 2'b00}) + 11'(s5_yoff);
        s5_hour_next  = s4_hour_reg;
        s5_rem_next   = s4_rem_reg;
        s5_mprod      = 23'(s4_rem_reg) * 23'(esdc_pkg::RECIP_60);
        s5_mq_next    = s5_mprod[21:16];
        s5_total_next = 38'(s4_edays_reg) * 38'(esdc_pkg::SECS_PER_DAY) + 38'(s4_tod_reg);
        s5_eok_next   = s4_eok_reg;
    end

    always_comb
    begin
        s6_func_next  = s5_func_reg;
        s6_year_next  = s5_year_reg;
        s6_doy_next   = s5_doy_reg;
        s6_leap_next  = s5_leap_reg;
        s6_hour_next  = s5_hour_reg;
        s6_sec0 = s5_rem_reg - (12'(s5_mq_reg) * 12'(esdc_pkg::SECS_PER_MIN));
        if (s6_sec0[6:0] >= 7'(esdc_pkg::SECS_PER_MIN))
        begin
            s6_minute_next = s5_mq_reg + 6'd1;
            s6_second_next = 6'(s6_sec0[6:0] - 7'(esdc_pkg::SECS_PER_MIN));
        end
        else
        begin
            s6_minute_next = s5_mq_reg;
            s6_second_next = s6_sec0[5:0];
        end
        s6_month_next = 4'd1;
        for (int k = 2; k <= 12; k++)
        begin
            if (s5_doy_reg >= esdc_pkg::month_start(4'(k), s5_leap_reg))
                s6_month_next = s6_month_next + 4'd1;
        end
        s6_err_next     = !(s5_eok_reg && (s5_total_reg[37:32] == 6'd0));
        s6_seconds_next = s6_err_next ? 32'd0 : s5_total_reg[31:0];
    end

    always_comb
    begin
        s7_day0 = s6_doy_reg - esdc_pkg::month_start(s6_month_reg, s6_leap_reg) + 9'd1;
        if (!s6_func_reg)
        begin
            s7_rsp_next.seconds_out = 32'd0;
            s7_rsp_next.year_out    = s6_year_reg;
            s7_rsp_next.month_out   = s6_month_reg;
            s7_rsp_next.day_out     = s7_day0[4:0];
            s7_rsp_next.hour_out    = s6_hour_reg;
            s7_rsp_next.minute_out  = s6_minute_reg;
            s7_rsp_next.second_out  = s6_second_reg;
            s7_rsp_next.error       = 1'b0;
        end
        else
        begin
            s7_rsp_next.seconds_out = s6_seconds_reg;
            s7_rsp_next.year_out    = 11'(esdc_pkg::EPOCH_YEAR);
            s7_rsp_next.month_out   = 4'd1;
            s7_rsp_next.day_out     = 5'd1;
            s7_rsp_next.hour_out    = 5'd0;
            s7_rsp_next.minute_out  = 6'd0;
            s7_rsp_next.second_out  = 6'd0;
            s7_rsp_next.error       = s6_err_reg;
        end
    end

    // hold all stages while the output stalls
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_cmd_reg     <= s1_cmd_next;
            s1_dq_reg      <= s1_dq_next;
            s1_eq_reg      <= s1_eq_next;
            s2_cmd_reg     <= s2_cmd_next;
            s2_days_reg    <= s2_days_next;
            s2_rem_reg     <= s2_rem_next;
            s2_q100_reg    <= s2_q100_next;
            s2_rz_reg      <= s2_rz_next;
            s2_leap_reg    <= s2_leap_next;
            s2_tod_reg     <= s2_tod_next;
            s2_fok_reg     <= s2_fok_next;
            s3_cmd_reg     <= s3_cmd_next;
            s3_dd_reg      <= s3_dd_next;
            s3_y4q_reg     <= s3_y4q_next;
            s3_rem_reg     <= s3_rem_next;
            s3_hq_reg      <= s3_hq_next;
            s3_dby_reg     <= s3_dby_next;
            s3_mdays_reg   <= s3_mdays_next;
            s3_eok_reg     <= s3_eok_next;
            s3_tod_reg     <= s3_tod_next;
            s4_func_reg    <= s4_func_next;
            s4_y4_reg      <= s4_y4_next;
            s4_r_reg       <= s4_r_next;
            s4_hour_reg    <= s4_hour_next;
            s4_rem_reg     <= s4_rem_next;
            s4_edays_reg   <= s4_edays_next;
            s4_eok_reg     <= s4_eok_next;
            s4_tod_reg     <= s4_tod_next;
            s5_func_reg    <= s5_func_next;
            s5_year_reg    <= s5_year_next;
            s5_doy_reg     <= s5_doy_next;
            s5_leap_reg    <= s5_leap_next;
            s5_hour_reg    <= s5_hour_next;
            s5_rem_reg     <= s5_rem_next;
            s5_mq_reg      <= s5_mq_next;
            s5_total_reg   <= s5_total_next;
            s5_eok_reg     <= s5_eok_next;
            s6_func_reg    <= s6_func_next;
            s6_year_reg    <= s6_year_next;
            s6_doy_reg     <= s6_doy_next;
            s6_leap_reg    <= s6_leap_next;
            s6_hour_reg    <= s6_hour_next;
            s6_minute_reg  <= s6_minute_next;
            s6_second_reg  <= s6_second_next;
            s6_month_reg   <= s6_month_next;
            s6_seconds_reg <= s6_seconds_next;
            s6_err_reg     <= s6_err_next;
            s7_rsp_reg     <= s7_rsp_next;
        end
    end

    `ESDC_ASSERT_SAME(a_stall_blocks_input, rsp.valid && !rsp.ready, !cmd.ready)
    `ESDC_ASSERT_NEXT(a_accept_fills_stage1, cmd.valid && cmd.ready, valid_reg[0])
    `ESDC_ASSERT_SAME(a_error_zero_seconds, rsp.valid && rsp.data.error, rsp.data.seconds_out == 32'd0)
    `ESDC_ASSERT_SAME(a_error_default_date, rsp.valid && rsp.data.error, rsp.data.month_out == 4'd1 && rsp.data.day_out == 5'd1)

endmodule
